@@ sv/gtft_pkg.sv @@
package gtft_pkg;

  localparam int MaxRows    = 64;
  localparam int MaxColumns = 64;
  localparam int PassCount  = 12;
  localparam int GridCells  = MaxRows * MaxColumns;
  localparam int AddrW      = $clog2(GridCells);
  localparam int SizeW      = 7;
  localparam int PassW      = $clog2(PassCount + 1);

  localparam logic signed [15:0] OneQ10 = 16'sd1024;
  localparam logic signed [15:0] MinQ   = -16'sd32768;

  localparam logic [1:0] RegLevel  = 2'd0;
  localparam logic [1:0] RegRows   = 2'd1;
  localparam logic [1:0] RegCols   = 2'd2;

  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpRun   = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;
  localparam logic [1:0] OpSpare = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] cell_value;
    logic               last_cell;
  } out_item_t;

  // Trim sequencer: per cell, issue eight tap reads (ST_T0), capture the last tap
  // (ST_T1), then decide/write (ST_DECIDE).
  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_WAIT, ST_T0, ST_T1, ST_DECIDE, ST_DONE
  } state_t;

  typedef struct packed {
    logic start_trim;
    logic tap_issue;
    logic [2:0] tap_sel;
    logic tap_capture;
    logic [2:0] cap_sel;
    logic decide;
    logic advance;
    logic emit_done;
    logic read_issue;
    logic emit_read;
  } cmd_t;

  typedef struct packed {
    logic trim_end;
  } status_t;

endpackage

@@ sv/gtft_ram.sv @@
module gtft_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/gtft_datapath.sv @@
module gtft_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  gtft_pkg::cmd_t                cmd,
  output gtft_pkg::status_t             status,
  input  logic                          load_en,
  input  logic signed [15:0]            load_sample,
  input  logic signed [15:0]            level,
  input  logic [gtft_pkg::SizeW-1:0]    row_count,
  input  logic [gtft_pkg::SizeW-1:0]    column_count,
  output gtft_pkg::out_item_t           result
);
  localparam int AW = gtft_pkg::AddrW;
  localparam int RW = $clog2(gtft_pkg::MaxRows + 1);
  localparam int CW = $clog2(gtft_pkg::MaxColumns + 1);
  localparam int SizeW = gtft_pkg::SizeW;

  logic [RW-1:0] rows;
  logic [CW-1:0] cols;
  logic [AW:0]   total;
  logic [AW:0]   load_pointer, read_pointer;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [gtft_pkg::PassW-1:0] pass;
  logic [AW:0]   base;
  logic [3:0]    below;
  logic signed [15:0] low_val;
  logic signed [16:0] low_wide;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic [AW:0]   lp_use, rp_use, tap_addr;
  logic          rin, cin, hit;
  logic          last_rd;

  always_comb begin
    if (row_count == '0) rows = RW'(1);
    else if (row_count > SizeW'(gtft_pkg::MaxRows)) rows = RW'(gtft_pkg::MaxRows);
    else rows = RW'(row_count);
    if (column_count == '0) cols = CW'(1);
    else if (column_count > SizeW'(gtft_pkg::MaxColumns)) cols = CW'(gtft_pkg::MaxColumns);
    else cols = CW'(column_count);
  end

  // Grid size in cells; a small 7 by 7 bit product that follows the size registers at once.
  assign total = (AW+1)'(rows) * (AW+1)'(cols);

  assign low_wide = 17'(level) - 17'(gtft_pkg::OneQ10);
  assign low_val  = (low_wide < 17'(gtft_pkg::MinQ)) ? gtft_pkg::MinQ : low_wide[15:0];

  assign lp_use = (load_pointer >= total) ? '0 : load_pointer;
  assign rp_use = (read_pointer >= total) ? '0 : read_pointer;

  always_comb begin
    unique case (cmd.tap_sel)
      3'd0:    tap_addr = base - (AW+1)'(cols);
      3'd1:    tap_addr = base + (AW+1)'(cols);
      3'd2:    tap_addr = base - 1'b1;
      3'd3:    tap_addr = base + 1'b1;
      3'd4:    tap_addr = base - (AW+1)'(cols) - 1'b1;
      3'd5:    tap_addr = base - (AW+1)'(cols) + 1'b1;
      3'd6:    tap_addr = base + (AW+1)'(cols) - 1'b1;
      default: tap_addr = base + (AW+1)'(cols) + 1'b1;
    endcase
  end

  assign rin = (row != '0) && (RW'(row + 1'b1) < rows);
  assign cin = (col != '0) && (CW'(col + 1'b1) < cols);

  // Taps 0 up, 1 down, 2 left, 3 right land in below; taps 4 up-left, 5 up-right,
  // 6 down-left and 7 down-right land in diag.
  logic [3:0] diag;
  assign hit = (rin && below[0] && below[1]) || (cin && below[2] && below[3]) ||
               (rin && cin && ((diag[0] && diag[3]) || (diag[1] && diag[2])));

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = lp_use[AW-1:0];
    ram_wdata = load_sample;
    ram_raddr = tap_addr[AW-1:0];
    if (load_en) begin
      ram_we = 1'b1;
    end else if (cmd.decide && hit) begin
      ram_we = 1'b1;
      ram_waddr = base[AW-1:0];
      ram_wdata = low_val;
    end
    if (cmd.read_issue) ram_raddr = rp_use[AW-1:0];
  end

  gtft_ram #(.Width(16), .Depth(gtft_pkg::GridCells)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign status.trim_end = (pass == gtft_pkg::PassW'(gtft_pkg::PassCount - 1)) &&
                           (RW'(row + 1'b1) == rows) && (CW'(col + 1'b1) == cols);

  always_ff @(posedge clk) begin
    if (cmd.tap_capture) begin
      if (cmd.cap_sel < 3'd4) below[cmd.cap_sel[1:0]] <= $signed(ram_rdata) < level;
      else diag[cmd.cap_sel[1:0]] <= $signed(ram_rdata) < level;
    end
    if (cmd.read_issue) last_rd <= (rp_use + 1'b1 >= total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer <= '0;
      read_pointer <= '0;
      row <= '0; col <= '0; pass <= '0; base <= '0;
      result <= '0;
    end else begin
      if (load_en) load_pointer <= (lp_use + 1'b1 >= total) ? '0 : lp_use + 1'b1;
      if (cmd.read_issue) read_pointer <= (rp_use + 1'b1 >= total) ? '0 : rp_use + 1'b1;
      if (cmd.start_trim) begin
        row <= '0; col <= '0; pass <= '0; base <= '0;
      end
      if (cmd.advance) begin
        if (CW'(col + 1'b1) == cols) begin
          col <= '0;
          if (RW'(row + 1'b1) == rows) begin
            row <= '0; base <= '0; pass <= pass + 1'b1;
          end else begin
            row <= row + 1'b1; base <= base + 1'b1;
          end
        end else begin
          col <= col + 1'b1; base <= base + 1'b1;
        end
      end
      if (cmd.emit_done) begin
        load_pointer <= '0;
        read_pointer <= '0;
        result <= '0;
      end
      if (cmd.emit_read) begin
        result.kind <= 1'b1;
        result.cell_value <= ram_rdata;
        result.last_cell <= last_rd;
      end
    end
  end
endmodule

@@ sv/gtft_ctrl.sv @@
module gtft_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  gtft_pkg::status_t   status,
  output gtft_pkg::cmd_t      cmd
);
  gtft_pkg::state_t state, state_next;
  logic out_valid_next;
  logic [2:0] tap, tap_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtft_pkg::ST_IDLE;
      out_valid <= 1'b0;
      tap <= '0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      tap <= tap_next;
    end
  end

  logic take;
  always_comb begin
    state_next = state;
    out_valid_next = out_valid && out_stall;
    tap_next = tap;
    cmd = '0;
    in_stall = 1'b1;
    take = 1'b0;
    unique case (state)
      gtft_pkg::ST_IDLE: begin
        // Loads pass freely; results need the output register free.
        in_stall = (in_op == gtft_pkg::OpLoad) ? 1'b0 : (out_valid && out_stall);
        take = in_valid && !in_stall;
        if (take && in_op == gtft_pkg::OpRun) begin
          cmd.start_trim = 1'b1;
          tap_next = '0;
          state_next = gtft_pkg::ST_T0;
        end else if (take && in_op == gtft_pkg::OpRead) begin
          cmd.read_issue = 1'b1;
          state_next = gtft_pkg::ST_RD_WAIT;
        end
      end
      gtft_pkg::ST_RD_WAIT: begin
        cmd.emit_read = 1'b1;
        out_valid_next = 1'b1;
        state_next = gtft_pkg::ST_IDLE;
      end
      gtft_pkg::ST_T0: begin
        // Issue tap reads; data of tap k arrives in the next cycle, as tap k+1 is issued.
        cmd.tap_sel = tap;
        cmd.tap_issue = 1'b1;
        if (tap != 3'd0) begin
          cmd.tap_capture = 1'b1;
          cmd.cap_sel = tap - 1'b1;
        end
        tap_next = tap + 1'b1;
        if (tap == 3'd7) state_next = gtft_pkg::ST_T1;
      end
      gtft_pkg::ST_T1: begin
        cmd.tap_capture = 1'b1;
        cmd.cap_sel = 3'd7;
        state_next = gtft_pkg::ST_DECIDE;
      end
      gtft_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.advance = 1'b1;
        tap_next = '0;
        state_next = status.trim_end ? gtft_pkg::ST_DONE : gtft_pkg::ST_T0;
      end
      gtft_pkg::ST_DONE: begin
        cmd.emit_done = 1'b1;
        out_valid_next = 1'b1;
        state_next = gtft_pkg::ST_IDLE;
      end
      default: state_next = gtft_pkg::ST_IDLE;
    endcase
  end
endmodule

@@ sv/grid_thin_feature_trim.sv @@
// Grid thin-feature trim. Cells are loaded (opcode load) and read back (opcode read)
// in raster order over a row_count by column_count grid held in one 4096-entry
// single-write RAM. A load transfer is taken every cycle while the block is idle; a
// read passes through the registered RAM read and a wait state, and its result sits
// in an output register. A run command sweeps the grid twelve times in place; each
// cell takes eight neighbor reads through the single RAM read port, a capture and a
// decide-and-write, and the run then returns one done result.
module grid_thin_feature_trim (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  gtft_pkg::in_item_t     in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output gtft_pkg::out_item_t    out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);
  logic signed [15:0] level;
  logic [gtft_pkg::SizeW-1:0] row_count, column_count;
  gtft_pkg::cmd_t cmd;
  gtft_pkg::status_t status;
  logic load_en;

  assign cfg_ready = 1'b1;

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 16'sd512;
      row_count <= gtft_pkg::SizeW'(64);
      column_count <= gtft_pkg::SizeW'(64);
    end else if (cfg_valid) begin
      if (cfg_index == gtft_pkg::RegLevel) level <= cfg_data;
      else if (cfg_index == gtft_pkg::RegRows) row_count <= cfg_data[gtft_pkg::SizeW-1:0];
      else if (cfg_index == gtft_pkg::RegCols) column_count <= cfg_data[gtft_pkg::SizeW-1:0];
    end
  end

  assign load_en = in_valid && !in_stall && (in_data.opcode == gtft_pkg::OpLoad);

  gtft_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_op(in_data.opcode),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .cmd(cmd)
  );

  gtft_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .load_en(load_en),
    .load_sample(in_data.sample), .level(level), .row_count(row_count),
    .column_count(column_count), .result(out_data)
  );
endmodule

@@ sv/gtft_checker.sv @@
module gtft_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input gtft_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("output changed");
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.kind |-> out_data.cell_value == '0 && !out_data.last_cell)
    else $error("done result not zero");
  a_ctl_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({out_valid, in_stall})) else $error("handshake unknown");
  a_data_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(out_data)) else $error("result unknown");
endmodule

bind grid_thin_feature_trim gtft_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
